// ----- rtl/vdl_pkg.sv -----
// Shared types and constants for the vertex diffuse lighting block.
// Used by every module under rtl/; no dependencies.
`default_nettype none

package vdl_pkg;

	localparam int LIGHT_SLOTS = 7;
	localparam int CNT_W      = 3;
	localparam int NORM_W     = 16;
	localparam int DIR_W      = 12;
	localparam int COL_W      = 8;
	localparam int FRAC_W     = 24;
	localparam int PROD_W     = NORM_W + DIR_W;
	localparam int DOT_W      = PROD_W + 2;
	localparam int POS_W      = PROD_W;
	localparam int TERM_W     = POS_W + COL_W;
	localparam int ACC_W      = COL_W + FRAC_W;
	localparam int SUM_W      = TERM_W + 1;

	localparam logic [ACC_W-1:0] ACC_FULL = ACC_W'(255) << FRAC_W;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_AMB = CFG_IDX_W'(7);

	// one light: rgb bytes low, direction x,y,z above
	typedef struct packed {
		logic [2:0][DIR_W-1:0] dir;
		logic [2:0][COL_W-1:0] col;
	} light_t;

	typedef struct packed {
		logic [CNT_W-1:0]      cnt;
		logic [2:0][COL_W-1:0] col;
	} amb_t;

	// what travels from cell to cell
	typedef struct packed {
		logic [2:0][NORM_W-1:0] nrm;
		logic [2:0][ACC_W-1:0]  acc;
	} item_t;

	typedef logic [2:0][COL_W-1:0] rgb_t;

endpackage

`default_nettype wire

// ----- rtl/vdl_cfg.sv -----
// APB register file: seven light registers and the ambient/count register.
// Depends on vdl_pkg.
`default_nettype none

module vdl_cfg
	import vdl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output light_t                     lights [LIGHT_SLOTS],
	output amb_t                       amb
);

	light_t               light_q [LIGHT_SLOTS];
	amb_t                 amb_q;
	logic [CFG_IDX_W-1:0] idx;
	logic                 wr;

	assign idx    = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIGHT_SLOTS; i++) light_q[i] <= '0;
			amb_q <= '0;
		end else if (wr) begin
			if (32'(idx) < LIGHT_SLOTS) begin
				light_q[idx] <= pwdata[$bits(light_t)-1:0];
			end else if (idx == REG_AMB) begin
				amb_q <= pwdata[$bits(amb_t)-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (32'(idx) < LIGHT_SLOTS) begin
			prdata = CFG_DATA_W'(light_q[idx]);
		end else if (idx == REG_AMB) begin
			prdata = CFG_DATA_W'(amb_q);
		end
	end

	assign lights = light_q;
	assign amb    = amb_q;

endmodule

`default_nettype wire

// ----- rtl/vdl_cell.sv -----
// One light cell of the chain: dot product, clamp, color scale, accumulate.
// Four register stages. Depends on vdl_pkg.
`default_nettype none

module vdl_cell
	import vdl_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   active,
	input  light_t      light,
	input  wire logic   in_valid,
	input  item_t       in_item,
	output logic        out_valid,
	output item_t       out_item
);

	logic signed [PROD_W-1:0] prod    [3];
	logic signed [PROD_W-1:0] prod_s1 [3];
	logic signed [DOT_W-1:0]  dot;
	logic [POS_W-1:0]         dot_pos;
	logic [POS_W-1:0]         dot_s2;
	logic [TERM_W-1:0]        term_s3 [3];
	logic [SUM_W-1:0]         sum     [3];
	item_t                    item_s1, item_s2, item_s3, item_s4;
	logic                     v_s1, v_s2, v_s3, v_s4;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = PROD_W'($signed(in_item.nrm[c])) * PROD_W'($signed(light.dir[c]));
		end
	end

	assign dot = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
	// only a strictly positive dot product of an enabled light contributes
	assign dot_pos = (active && !dot[DOT_W-1] && dot != '0) ? dot[POS_W-1:0] : '0;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = SUM_W'(item_s3.acc[c]) + SUM_W'(term_s3[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			for (int c = 0; c < 3; c++) prod_s1[c] <= prod[c];
			item_s2 <= item_s1;
			dot_s2  <= dot_pos;
			item_s3 <= item_s2;
			for (int c = 0; c < 3; c++) begin
				term_s3[c] <= TERM_W'(light.col[c]) * TERM_W'(dot_s2);
			end
			item_s4.nrm <= item_s3.nrm;
			// all terms are non-negative, so clamping every step matches a final clamp
			for (int c = 0; c < 3; c++) begin
				item_s4.acc[c] <= (sum[c] >= SUM_W'(ACC_FULL)) ? ACC_FULL
					: sum[c][ACC_W-1:0];
			end
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;

endmodule

`default_nettype wire

// ----- rtl/vdl_obuf.sv -----
// Output register with one skid entry so the chain keeps moving while a
// result waits. Depends on vdl_pkg.
`default_nettype none

module vdl_obuf
	import vdl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  rgb_t      in_rgb,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_ready,
	output rgb_t      out_rgb
);

	logic out_v_q, skid_v_q;
	rgb_t out_q, skid_q;
	logic pop, push;

	assign pop  = out_v_q && out_ready;
	assign push = in_valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					skid_v_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_v_q || pop) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_q <= in_rgb;
			end else begin
				skid_q <= in_rgb;
			end
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_rgb   = out_q;

endmodule

`default_nettype wire

// ----- rtl/vertex_diffuse_lighting_top.sv -----
// Vertex diffuse lighting: ambient plus up to seven Lambert lights per normal.
// Depends on vdl_pkg, vdl_cfg, vdl_cell, vdl_obuf.
//
//  channel | dir | width | contents
//  s_axis  | in  | 48    | normal_x, normal_y, normal_z (signed Q2.14)
//  m_axis  | out | 24    | red, green, blue
//  apb     | in  | 64    | light_0..light_6 at 8*i, ambient_and_count at 0x38
//
// One vertex per cycle while the chain is not halted. Each vertex passes four
// stages in each of the seven light cells plus the output register. Reset clears
// the valid bits and the configuration registers. The chain halts only when both
// the output register and its skid entry are full.
`default_nettype none

module vertex_diffuse_lighting_top
	import vdl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [47:0]           s_tdata,  // normal_x, normal_y, normal_z
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [23:0]           m_tdata,  // red, green, blue
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	light_t lights [LIGHT_SLOTS];
	amb_t   amb;
	logic   en, full;
	logic   act   [LIGHT_SLOTS];
	logic   valid [LIGHT_SLOTS+1];
	item_t  chain [LIGHT_SLOTS+1];
	rgb_t   rgb, out_rgb;

	vdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.lights  (lights),
		.amb     (amb)
	);

	assign en       = !full;
	assign s_tready = en;

	always_comb begin
		valid[0] = s_tvalid;
		for (int c = 0; c < 3; c++) begin
			chain[0].nrm[c] = s_tdata[c*NORM_W +: NORM_W];
			chain[0].acc[c] = ACC_W'(amb.col[c]) << FRAC_W;
		end
	end

	for (genvar k = 0; k < LIGHT_SLOTS; k++) begin : g_cell
		assign act[k] = 32'(amb.cnt) > k;

		vdl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.active    (act[k]),
			.light     (lights[k]),
			.in_valid  (valid[k]),
			.in_item   (chain[k]),
			.out_valid (valid[k+1]),
			.out_item  (chain[k+1])
		);
	end

	// accumulator is already clamped at full scale
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rgb[c] = chain[LIGHT_SLOTS].acc[c][ACC_W-1:FRAC_W];
		end
	end

	vdl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid[LIGHT_SLOTS] && en),
		.in_rgb    (rgb),
		.full      (full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rgb   (out_rgb)
	);

	assign m_tdata = out_rgb;

endmodule

`default_nettype wire
